// File: hw/rtl/tnmp_pkg.sv
`timescale 1ns / 1ps

package tnmp_pkg;

    localparam int unsigned COMP_W     = 16;
    localparam int unsigned VEC_W      = 3 * COMP_W;
    localparam int unsigned IN_W       = 5 * VEC_W;
    localparam int unsigned SCALE_W    = 16;
    localparam int unsigned MAG_W      = 32;
    localparam int unsigned NMAG_W     = 31;
    localparam int unsigned LEN2_W     = 64;
    localparam int unsigned ROOT_W     = 32;
    localparam int unsigned REM_W      = 36;
    localparam int unsigned Q_W        = 15;
    localparam int unsigned NUM_W      = 46;
    localparam int unsigned SQ_STAGES  = ROOT_W / 2;
    localparam int unsigned DV_STAGES  = Q_W;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'h1000;

    typedef struct packed {
        logic [VEC_W-1:0] old_normal;
        logic [2:0]       neg;
        logic             degen;
    } side_t;

    typedef struct packed {
        side_t                  side;
        logic [2:0][NMAG_W-1:0] m;
        logic [LEN2_W-1:0]      len2;
    } sq_in_t;

    typedef struct packed {
        side_t                  side;
        logic [2:0][NMAG_W-1:0] m;
        logic [ROOT_W-1:0]      root;
    } dv_in_t;

    typedef struct packed {
        side_t             side;
        logic [2:0][Q_W-1:0] q;
    } fin_t;

    // one digit of the square root: returns {rem, root}
    function automatic logic [REM_W+ROOT_W-1:0] sqrt_step(input logic [REM_W-1:0] rem,
                                                          input logic [ROOT_W-1:0] root,
                                                          input logic [1:0] bits);
        logic [REM_W-1:0]  r;
        logic [REM_W-1:0]  t;
        logic [ROOT_W-1:0] rt;
        r = {rem[REM_W-3:0], bits};
        t = {2'b00, root, 2'b01};
        if (r >= t) begin
            r  = r - t;
            rt = {root[ROOT_W-2:0], 1'b1};
        end else begin
            rt = {root[ROOT_W-2:0], 1'b0};
        end
        return {r, rt};
    endfunction

endpackage

// File: hw/rtl/tnmp_front.sv
`timescale 1ns / 1ps

module tnmp_front
    import tnmp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [IN_W-1:0]          in_data,
    input  logic signed [SCALE_W-1:0] xy_scale,
    output logic                     out_valid,
    output side_t                    out_side,
    output logic [2:0][MAG_W-1:0]    out_m
);

    // stage 1: clamp, map, scale
    logic [3:0]               v_reg;
    logic signed [29:0]       px_reg, py_reg;
    logic signed [13:0]       nz_reg;
    logic [3*VEC_W-1:0]       f1_frame_reg;
    logic [VEC_W-1:0]         f1_old_reg;
    logic signed [13:0]       n_next [3];
    logic [12:0]              c;
    logic signed [COMP_W-1:0] ch;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ch = $signed(in_data[COMP_W*k +: COMP_W]);
            if (ch < 0) begin
                c = 13'd0;
            end else if (ch > 16'sd4096) begin
                c = 13'd4096;
            end else begin
                c = ch[12:0];
            end
            n_next[k] = $signed({c, 1'b0} - 14'd4096);
        end
    end

    // stage 2: round and saturate
    logic signed [COMP_W-1:0] xs_reg, ys_reg, zs_reg;
    logic [3*VEC_W-1:0]       f2_frame_reg;
    logic [VEC_W-1:0]         f2_old_reg;
    logic signed [COMP_W-1:0] xs_next, ys_next;

    function automatic logic signed [COMP_W-1:0] rnd_sat(input logic signed [29:0] p);
        logic signed [30:0] v;
        logic signed [18:0] sh;
        v  = {p[29], p} + 31'sd2048;
        sh = v[30:12];
        if (sh > 19'sd32767) begin
            return 16'sh7fff;
        end else if (sh < -19'sd32768) begin
            return 16'sh8000;
        end
        return sh[15:0];
    endfunction

    assign xs_next = rnd_sat(px_reg);
    assign ys_next = rnd_sat(py_reg);

    // stage 3: nine products
    logic signed [31:0]       prod_reg [3][3];
    logic [VEC_W-1:0]         f3_old_reg;
    logic signed [COMP_W-1:0] coef [3];

    assign coef[0] = xs_reg;
    assign coef[1] = ys_reg;
    assign coef[2] = zs_reg;

    // stage 4: sum and magnitude
    logic [2:0][MAG_W-1:0] m_reg;
    logic [2:0]            neg_reg;
    logic [VEC_W-1:0]      f4_old_reg;
    logic signed [33:0]    w [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w[k] = 34'(prod_reg[k][0]) + 34'(prod_reg[k][1]) + 34'(prod_reg[k][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg       <= n_next[0] * xy_scale;
            py_reg       <= n_next[1] * xy_scale;
            nz_reg       <= n_next[2];
            f1_frame_reg <= in_data[VEC_W +: 3*VEC_W];
            f1_old_reg   <= in_data[4*VEC_W +: VEC_W];

            xs_reg       <= xs_next;
            ys_reg       <= ys_next;
            zs_reg       <= 16'(nz_reg);
            f2_frame_reg <= f1_frame_reg;
            f2_old_reg   <= f1_old_reg;

            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[k][j] <= coef[j] *
                        $signed(f2_frame_reg[VEC_W*j + COMP_W*k +: COMP_W]);
                end
            end
            f3_old_reg <= f2_old_reg;

            for (int k = 0; k < 3; k++) begin
                neg_reg[k] <= w[k][33];
                m_reg[k]   <= w[k][33] ? MAG_W'(-w[k]) : MAG_W'(w[k]);
            end
            f4_old_reg <= f3_old_reg;
        end
    end

    assign out_valid            = v_reg[3];
    assign out_m                = m_reg;
    assign out_side.old_normal  = f4_old_reg;
    assign out_side.neg         = neg_reg;
    assign out_side.degen       = 1'b0;

endmodule

// File: hw/rtl/tnmp_norm.sv
`timescale 1ns / 1ps

module tnmp_norm
    import tnmp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  side_t                 in_side,
    input  logic [2:0][MAG_W-1:0] in_m,
    output logic                  out_valid,
    output sq_in_t                out_data
);

    logic [4:0]            v_reg;
    side_t                 s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic [2:0][MAG_W-1:0] m1_reg, m2_reg;
    logic [MAG_W-1:0]      max_reg;
    logic [4:0]            pos_reg;
    logic [2:0][NMAG_W-1:0] ms_reg, ms4_reg, ms5_reg;
    logic [2:0][61:0]      sq_reg;
    logic [LEN2_W-1:0]     len2_reg;

    logic [MAG_W-1:0]      max01, max_next;
    logic [4:0]            pos_next;
    logic [4:0]            lsh;
    logic [2:0][NMAG_W-1:0] ms_next;
    side_t                 s1_next;

    always_comb begin
        max01    = (in_m[0] > in_m[1]) ? in_m[0] : in_m[1];
        max_next = (max01 > in_m[2]) ? max01 : in_m[2];
        s1_next       = in_side;
        s1_next.degen = (max_next == '0);
    end

    always_comb begin
        pos_next = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (max_reg[i]) begin
                pos_next = 5'(i);
            end
        end
    end

    always_comb begin
        lsh = 5'(5'd30 - pos_reg);
        for (int k = 0; k < 3; k++) begin
            if (pos_reg == 5'd31) begin
                ms_next[k] = m2_reg[k][MAG_W-1:1];
            end else begin
                ms_next[k] = NMAG_W'(m2_reg[k] << lsh);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg   <= s1_next;
            m1_reg   <= in_m;
            max_reg  <= max_next;

            s2_reg   <= s1_reg;
            m2_reg   <= m1_reg;
            pos_reg  <= pos_next;

            s3_reg   <= s2_reg;
            ms_reg   <= ms_next;

            s4_reg   <= s3_reg;
            ms4_reg  <= ms_reg;
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= ms_reg[k] * ms_reg[k];
            end

            s5_reg   <= s4_reg;
            ms5_reg  <= ms4_reg;
            len2_reg <= LEN2_W'(sq_reg[0]) + LEN2_W'(sq_reg[1]) + LEN2_W'(sq_reg[2]);
        end
    end

    assign out_valid     = v_reg[4];
    assign out_data.side = s5_reg;
    assign out_data.m    = ms5_reg;
    assign out_data.len2 = len2_reg;

endmodule

// File: hw/rtl/tnmp_isqrt.sv
`timescale 1ns / 1ps

module tnmp_isqrt
    import tnmp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  sq_in_t in_data,
    output logic   out_valid,
    output dv_in_t out_data
);

    logic [SQ_STAGES-1:0] v_reg;
    sq_in_t               d_reg    [SQ_STAGES];
    logic [REM_W-1:0]     rem_reg  [SQ_STAGES];
    logic [ROOT_W-1:0]    root_reg [SQ_STAGES];
    logic [REM_W-1:0]     rem_next [SQ_STAGES];
    logic [ROOT_W-1:0]    root_next[SQ_STAGES];

    always_comb begin
        logic [REM_W-1:0]  r;
        logic [ROOT_W-1:0] rt;
        logic [LEN2_W-1:0] l;
        for (int s = 0; s < SQ_STAGES; s++) begin
            if (s == 0) begin
                r  = '0;
                rt = '0;
                l  = in_data.len2;
            end else begin
                r  = rem_reg[s-1];
                rt = root_reg[s-1];
                l  = d_reg[s-1].len2;
            end
            for (int j = 0; j < 2; j++) begin
                {r, rt} = sqrt_step(r, rt, l[2*(ROOT_W-1-2*s-j) +: 2]);
            end
            rem_next[s]  = r;
            root_next[s] = rt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[SQ_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < SQ_STAGES; s++) begin
                d_reg[s]    <= (s == 0) ? in_data : d_reg[s-1];
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
        end
    end

    assign out_valid     = v_reg[SQ_STAGES-1];
    assign out_data.side = d_reg[SQ_STAGES-1].side;
    assign out_data.m    = d_reg[SQ_STAGES-1].m;
    assign out_data.root = root_reg[SQ_STAGES-1];

endmodule

// File: hw/rtl/tnmp_div.sv
`timescale 1ns / 1ps

module tnmp_div
    import tnmp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  dv_in_t in_data,
    output logic   out_valid,
    output fin_t   out_data
);

    logic [DV_STAGES-1:0]    v_reg;
    side_t                   side_reg [DV_STAGES];
    logic [ROOT_W-1:0]       den_reg  [DV_STAGES];
    logic [2:0][NUM_W-1:0]   rem_reg  [DV_STAGES];
    logic [2:0][Q_W-1:0]     q_reg    [DV_STAGES];
    logic [2:0][NUM_W-1:0]   rem_next [DV_STAGES];
    logic [2:0][Q_W-1:0]     q_next   [DV_STAGES];

    // restoring division, one quotient bit per stage, bit 14 first
    always_comb begin
        logic [NUM_W-1:0]  r;
        logic [Q_W-1:0]    q;
        logic [ROOT_W-1:0] d;
        logic [NUM_W-1:0]  t;
        for (int s = 0; s < DV_STAGES; s++) begin
            d = (s == 0) ? in_data.root : den_reg[s-1];
            t = NUM_W'(d) << (Q_W - 1 - s);
            for (int k = 0; k < 3; k++) begin
                if (s == 0) begin
                    r = {1'b0, in_data.m[k], 14'd0} + NUM_W'(in_data.root[ROOT_W-1:1]);
                    q = '0;
                end else begin
                    r = rem_reg[s-1][k];
                    q = q_reg[s-1][k];
                end
                if (r >= t) begin
                    r = r - t;
                    q[Q_W-1-s] = 1'b1;
                end
                rem_next[s][k] = r;
                q_next[s][k]   = q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[DV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < DV_STAGES; s++) begin
                side_reg[s] <= (s == 0) ? in_data.side : side_reg[s-1];
                den_reg[s]  <= (s == 0) ? in_data.root : den_reg[s-1];
                rem_reg[s]  <= rem_next[s];
                q_reg[s]    <= q_next[s];
            end
        end
    end

    assign out_valid     = v_reg[DV_STAGES-1];
    assign out_data.side = side_reg[DV_STAGES-1];
    assign out_data.q    = q_reg[DV_STAGES-1];

endmodule

// File: hw/rtl/tangent_normal_map_perturb_top.sv
`timescale 1ns / 1ps
// Tangent-space normal map perturbation, one shading sample per transfer.
// Input stream s_*: tdata carries color_rgb, frame_tangent, frame_bitangent,
// frame_normal and old_normal, 48 bits each, color_rgb in the low bits.
// Output stream m_*: tdata is new_normal (x,y,z Q2.14), tuser is degenerate.
// Config channel cfg_*: writes xy_scale (signed Q4.12); cfg_ready is always
// high. Write it only while no sample is in flight.
// Throughput: one sample per cycle while m_tready takes results; no dependence
// between samples. The pipeline has 42 register stages, the first loading at
// the input transfer edge: 4 front, 5 normalize, 16 square-root at two root
// bits each, 15 divide at one quotient bit each, 1 sign stage, output register.
// The whole pipeline advances on one enable. A 2-entry output buffer lets the
// pipeline keep moving while a result waits; once its second entry fills,
// s_tready drops and the pipeline holds until m_tready takes a result.
// Nothing is lost or repeated across stalls.
// Reset (aresetn low, synchronous) empties the pipeline and the output buffer
// and sets xy_scale to 1.0.

module tangent_normal_map_perturb_top
    import tnmp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // color_rgb, frame_tangent, frame_bitangent, frame_normal, old_normal
    input  logic [IN_W-1:0]    s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // new_normal
    output logic [VEC_W-1:0]   m_tdata,
    // degenerate
    output logic               m_tuser,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SCALE_W-1:0] cfg_data
);

    logic [SCALE_W-1:0] xy_scale_reg;
    logic               en;
    logic               in_valid;

    logic                  fr_valid;
    side_t                 fr_side;
    logic [2:0][MAG_W-1:0] fr_m;
    logic                  nm_valid;
    sq_in_t                nm_data;
    logic                  sq_valid;
    dv_in_t                sq_data;
    logic                  dv_valid;
    fin_t                  dv_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xy_scale_reg <= SCALE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            xy_scale_reg <= cfg_data;
        end
    end

    assign in_valid = s_tvalid && s_tready;

    tnmp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (s_tdata),
        .xy_scale  ($signed(xy_scale_reg)),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_m     (fr_m)
    );

    tnmp_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_m      (fr_m),
        .out_valid (nm_valid),
        .out_data  (nm_data)
    );

    tnmp_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (nm_valid),
        .in_data   (nm_data),
        .out_valid (sq_valid),
        .out_data  (sq_data)
    );

    tnmp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_data   (sq_data),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    // sign stage: apply component signs, dot with old normal
    logic                            t1_valid_reg;
    logic                            t1_degen_reg;
    logic signed [2:0][COMP_W-1:0]   r_reg;
    logic signed [31:0]              dp_reg [3];
    logic signed [COMP_W-1:0]        r_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            r_next[k] = dv_data.side.neg[k] ? -$signed({1'b0, dv_data.q[k]})
                                             :  $signed({1'b0, dv_data.q[k]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_valid_reg <= 1'b0;
        end else if (en) begin
            t1_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_degen_reg <= dv_data.side.degen;
            for (int k = 0; k < 3; k++) begin
                r_reg[k]  <= r_next[k];
                dp_reg[k] <= r_next[k] *
                             $signed(dv_data.side.old_normal[COMP_W*k +: COMP_W]);
            end
        end
    end

    logic signed [33:0] dot;
    logic [VEC_W-1:0]   res_normal;

    always_comb begin
        dot = 34'(dp_reg[0]) + 34'(dp_reg[1]) + 34'(dp_reg[2]);
        for (int k = 0; k < 3; k++) begin
            if (t1_degen_reg) begin
                res_normal[COMP_W*k +: COMP_W] = '0;
            end else if (dot < 0) begin
                res_normal[COMP_W*k +: COMP_W] = -r_reg[k];
            end else begin
                res_normal[COMP_W*k +: COMP_W] = r_reg[k];
            end
        end
    end

    // output register plus skid entry
    logic               out_valid_reg;
    logic [VEC_W-1:0]   out_normal_reg;
    logic               out_degen_reg;
    logic               skid_valid_reg;
    logic [VEC_W-1:0]   skid_normal_reg;
    logic               skid_degen_reg;
    logic               push;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign push     = en && t1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_tready) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (push) begin
                if (out_valid_reg && !m_tready) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_normal_reg <= skid_normal_reg;
                out_degen_reg  <= skid_degen_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !m_tready) begin
                skid_normal_reg <= res_normal;
                skid_degen_reg  <= t1_degen_reg;
            end else begin
                out_normal_reg <= res_normal;
                out_degen_reg  <= t1_degen_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_normal_reg;
    assign m_tuser  = out_degen_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate result with nonzero normal");

    a_normal_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata != '0))
        else $error("zero normal without degenerate flag");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input blocked while no result is pending");

endmodule
